// ===== sv/lpht_pkg.sv =====
// Package for the linear probing hash table: sizes, codes, state type and
// helper functions for key trimming, hashing and index formatting.
// No dependencies.
package lpht_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 16;
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 64;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 4;
    localparam int IN_W   = ((CMD_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_W  = ((STAT_W + SLOT_W + 7) / 8) * 8;

    // Home slot arithmetic: byte sum, then reduction modulo TABLE_SIZE
    localparam int SUM_MAX   = KEY_BYTES * 255;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam bit SIZE_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam int RED_RAW   = $clog2(SUM_MAX / TABLE_SIZE + 1);
    localparam int RED_STEPS = (RED_RAW > 1) ? RED_RAW : 1;
    localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int RED_W     = SUM_W + RED_STEPS;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_PROBE
    } state_t;

    // Keep only the low KEY_BYTES bytes of a key
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    // Unsigned sum of the key bytes
    function automatic logic [SUM_W-1:0] key_sum(input logic [KEY_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            s = s + SUM_W'(k[8*b +: 8]);
        end
        return s;
    endfunction

    // Slot number reported modulo 16
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int b = 0; b < SLOT_W; b++)
        begin
            if (b < IDX_W)
            begin
                r[b] = i[b];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/linear_probe_hash_table.sv =====
// Linear probing hash table: streaming request in, one result out per request.
// Depends on lpht_pkg.
//
// Usage:
//   Slave channel s_*: one request per beat, tdata = {key, cmd} from bit 0 up
//   (cmd 0 insert, 1 search, 2 delete). Master channel m_*: one result per
//   request, tdata = {slot_index, status} (status 0 ok, 1 full, 2 not found).
// Timing:
//   A request is taken while idle, then the probe unit checks one slot per
//   cycle, starting at the home slot, until it can load the result; the last
//   probe step holds while the output register is full. When TABLE_SIZE is
//   not a power of two, the modulo reduction of the byte sum first runs its
//   compare and subtract steps in S_REDUCE. The single probe loop sets the
//   rate: one request at a time, s_tready high only while idle.
// Stall:
//   The result sits in an output register. If it is not taken, the next
//   request is still accepted and probed; it holds its last probe step until
//   the output register frees up.
// Reset:
//   rst_n clears all slot valid bits at once (table empty); no clearing pass.
module linear_probe_hash_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lpht_pkg::IN_W-1:0] s_tdata,   // cmd[1:0], key[65:2], zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lpht_pkg::OUT_W-1:0] m_tdata   // status[1:0], slot_index[5:2], pad
);

    localparam int TS    = lpht_pkg::TABLE_SIZE;
    localparam int IDX_W = lpht_pkg::IDX_W;
    localparam int CNT_W = lpht_pkg::CNT_W;
    localparam int KEY_W = lpht_pkg::KEY_W;
    localparam int SUM_W = lpht_pkg::SUM_W;
    localparam int RED_W = lpht_pkg::RED_W;

    // Control state
    lpht_pkg::state_t state_reg, state_next;
    logic [TS-1:0]                   valid_reg, valid_next;
    logic                            m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [lpht_pkg::STEP_W-1:0]     step_reg, step_next;

    // Payload
    logic [lpht_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_W-1:0]                key_reg, key_next;
    logic [SUM_W-1:0]                rem_reg, rem_next;
    logic [lpht_pkg::STAT_W-1:0]     stat_reg, stat_next;
    logic [lpht_pkg::SLOT_W-1:0]     slot_reg, slot_next;

    // Key storage, one entry read per cycle at the probe index
    logic [KEY_W-1:0]                key_mem_reg [TS];
    logic [KEY_W-1:0]                key_rd_reg;

    // Datapath
    logic [KEY_W-1:0]                in_key;
    logic [SUM_W-1:0]                in_sum;
    logic [RED_W-1:0]                sub_val;
    logic                            slot_full;
    logic                            hit;
    logic [IDX_W-1:0]                idx_adv;
    logic                            out_free;
    logic                            ins_we;
    logic                            fin;

    assign in_key   = lpht_pkg::trim_key(s_tdata[lpht_pkg::CMD_W +: KEY_W]);
    assign in_sum   = lpht_pkg::key_sum(in_key);
    assign sub_val  = RED_W'(TS) << step_reg;
    assign slot_full = valid_reg[idx_reg];
    assign hit      = slot_full && (key_rd_reg == key_reg);
    assign idx_adv  = (idx_reg == IDX_W'(TS - 1)) ? '0 : idx_reg + 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == lpht_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lpht_pkg::OUT_W - lpht_pkg::STAT_W - lpht_pkg::SLOT_W){1'b0}},
                       slot_reg, stat_reg};

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lpht_pkg::S_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        rem_reg  <= rem_next;
        stat_reg <= stat_next;
        slot_reg <= slot_next;
    end

    // Key store: write on a successful insert, read ahead at the next probe index
    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            key_mem_reg[idx_reg] <= key_reg;
        end
        key_rd_reg <= key_mem_reg[idx_next];
    end

    // Sequencer: accept, reduce hash, probe one slot per cycle, wait for output
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        stat_next    = stat_reg;
        slot_next    = slot_reg;
        ins_we       = 1'b0;
        fin          = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = s_tdata[lpht_pkg::CMD_W-1:0];
                    key_next  = in_key;
                    rem_next  = in_sum;
                    cnt_next  = '0;
                    idx_next  = in_sum[IDX_W-1:0];
                    step_next = lpht_pkg::STEP_W'(lpht_pkg::RED_STEPS - 1);
                    state_next = lpht_pkg::SIZE_POW2 ? lpht_pkg::S_PROBE
                                                     : lpht_pkg::S_REDUCE;
                end
            end

            lpht_pkg::S_REDUCE:
            begin
                // restoring modulo: one compare and subtract per cycle
                if (RED_W'(rem_reg) >= sub_val)
                begin
                    rem_next = rem_reg - sub_val[SUM_W-1:0];
                end
                idx_next = rem_next[IDX_W-1:0];
                if (step_reg == '0)
                begin
                    state_next = lpht_pkg::S_PROBE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            lpht_pkg::S_PROBE:
            begin
                case (cmd_reg)
                    lpht_pkg::CMD_INSERT:
                    begin
                        if (!slot_full)
                        begin
                            fin       = 1'b1;
                            stat_next = lpht_pkg::STAT_OK;
                        end
                        else if (cnt_reg == CNT_W'(TS - 1))
                        begin
                            fin       = 1'b1;
                            stat_next = lpht_pkg::STAT_FULL;
                        end
                    end
                    lpht_pkg::CMD_SEARCH,
                    lpht_pkg::CMD_DELETE:
                    begin
                        // an empty home slot does not end the search
                        if (cnt_reg != '0 && !slot_full)
                        begin
                            fin       = 1'b1;
                            stat_next = lpht_pkg::STAT_MISSING;
                        end
                        else if (hit)
                        begin
                            fin       = 1'b1;
                            stat_next = lpht_pkg::STAT_OK;
                        end
                        else if (cnt_reg == CNT_W'(TS - 1))
                        begin
                            fin       = 1'b1;
                            stat_next = lpht_pkg::STAT_MISSING;
                        end
                    end
                    default:
                    begin
                        fin       = 1'b1;
                        stat_next = lpht_pkg::STAT_MISSING;
                    end
                endcase

                if (fin)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        state_next   = lpht_pkg::S_IDLE;
                        slot_next    = (stat_next == lpht_pkg::STAT_OK)
                                       ? lpht_pkg::to_slot(idx_reg) : '0;
                        if (stat_next == lpht_pkg::STAT_OK)
                        begin
                            if (cmd_reg == lpht_pkg::CMD_INSERT)
                            begin
                                valid_next[idx_reg] = 1'b1;
                                ins_we              = 1'b1;
                            end
                            else if (cmd_reg == lpht_pkg::CMD_DELETE)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        // hold this step until the result register frees
                        stat_next = stat_reg;
                    end
                end
                else
                begin
                    idx_next = idx_adv;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a request was in progress");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpht_pkg::S_PROBE |-> cnt_reg < CNT_W'(TS))
        else $error("probe ran past the table size");

    a_err_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && stat_reg != lpht_pkg::STAT_OK |-> slot_reg == '0)
        else $error("slot index not zero on error status");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ins_we |=> valid_reg[$past(idx_reg)])
        else $error("insert did not mark its slot valid");

    a_result_only_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        fin && !out_free |=> state_reg == lpht_pkg::S_PROBE && $stable(idx_reg))
        else $error("probe advanced while the result register was busy");

endmodule

// ===== test/tb_linear_probe_hash_table.sv =====
// Self-checking testbench for linear_probe_hash_table: streams insert, search
// and delete requests, predicts every result with a table model of its own.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

    localparam int          IDLE_PCT   = 22;
    localparam int          RAND_ITEMS = 1700;
    localparam int          POOL_N     = 16;
    localparam int          STALL_LEN  = 250;
    localparam int          STALL_AT   = 300;
    localparam int          TAIL_WAIT  = 40;
    // slowest gap: receiver hold-off plus random stalls and a full-table probe
    localparam int          WATCHDOG   = 2000;
    localparam int          TS         = lpht_pkg::TABLE_SIZE;
    localparam int          CMD_W      = lpht_pkg::CMD_W;
    localparam int          KEY_W      = lpht_pkg::KEY_W;
    localparam int          STAT_W     = lpht_pkg::STAT_W;
    localparam int          SLOT_W     = lpht_pkg::SLOT_W;
    localparam int          IN_W       = lpht_pkg::IN_W;
    localparam int          OUT_W      = lpht_pkg::OUT_W;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } table_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } table_rsp_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    // Table model and request/result stores
    logic [KEY_W-1:0]    table_key  [TS];
    bit                  table_used [TS];
    table_req_t          request_q[$];
    table_rsp_t          predicted_results[$];
    logic [KEY_W-1:0]    pool_key [POOL_N];

    int                  err_cnt     = 0;
    int                  rsp_cnt     = 0;
    int                  n_ok        = 0;
    int                  n_full      = 0;
    int                  n_missing   = 0;
    int                  hold_cnt    = 0;
    int                  stall_cycles = 0;
    bit                  held        = 1'b0;
    bit                  quiet       = 1'b0;

    table_req_t          drv_req;
    table_rsp_t          got_rsp;
    table_rsp_t          want_rsp;

    linear_probe_hash_table dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // cmd[1:0], key[65:2], zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // status[1:0], slot_index[5:2], pad
    );

    always #4 clk = ~clk;

    // Apply one request to the table model and return its result
    function automatic table_rsp_t apply_table_op(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_W-1:0] raw_key);
        logic [KEY_W-1:0] k;
        int               sum;
        int               home;
        int               i;
        bit               hit;
        table_rsp_t       res;
        k   = '0;
        sum = 0;
        for (int b = 0; b < lpht_pkg::KEY_BYTES && b < 8; b++)
        begin
            k[8*b +: 8] = raw_key[8*b +: 8];
        end
        for (int b = 0; b < 8; b++)
        begin
            sum += int'(k[8*b +: 8]);
        end
        home       = sum % TS;
        res.status = lpht_pkg::STAT_MISSING;
        res.slot   = '0;
        hit        = 1'b0;
        i          = home;
        case (cmd)
            lpht_pkg::CMD_INSERT:
            begin
                res.status = lpht_pkg::STAT_FULL;
                for (int n = 0; n < TS; n++)
                begin
                    i = (home + n) % TS;
                    if (!table_used[i])
                    begin
                        table_used[i] = 1'b1;
                        table_key[i]  = k;
                        res.status    = lpht_pkg::STAT_OK;
                        res.slot      = SLOT_W'(i);
                        break;
                    end
                end
            end
            lpht_pkg::CMD_SEARCH, lpht_pkg::CMD_DELETE:
            begin
                // home first; an empty home does not end the probe
                if (table_used[home] && table_key[home] == k)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    for (int n = 1; n < TS; n++)
                    begin
                        i = (home + n) % TS;
                        if (!table_used[i])
                        begin
                            break;
                        end
                        if (table_key[i] == k)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                end
                if (hit)
                begin
                    res.status = lpht_pkg::STAT_OK;
                    res.slot   = SLOT_W'(i);
                    if (cmd == lpht_pkg::CMD_DELETE)
                    begin
                        table_used[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Short key of random length, zero padded above its last character
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        int               nb;
        k  = {$urandom, $urandom};
        nb = $urandom_range(1, 8);
        if (nb < 8)
        begin
            k = k & ((64'h1 << (8 * nb)) - 64'h1);
        end
        if (k == '0)
        begin
            k = 64'h1;
        end
        return k;
    endfunction

    task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        table_req_t r;
        r.cmd = cmd;
        r.key = key;
        request_q.push_back(r);
    endtask

    // Wait until every request has been taken and answered
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (request_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drv_req  = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'({drv_req.key, drv_req.cmd});
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: check output first, then predict the request taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_rsp.status = m_tdata[STAT_W-1:0];
                got_rsp.slot   = m_tdata[STAT_W +: SLOT_W];
                rsp_cnt++;
                if (predicted_results.size() == 0)
                begin
                    $error("result with none pending: status %0d, slot_index %0d",
                           got_rsp.status, got_rsp.slot);
                    err_cnt++;
                end
                else
                begin
                    want_rsp = predicted_results.pop_front();
                    if (got_rsp.status !== want_rsp.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want_rsp.status, got_rsp.status);
                        err_cnt++;
                    end
                    if (got_rsp.slot !== want_rsp.slot)
                    begin
                        $error("slot_index mismatch: expected %0d, got %0d",
                               want_rsp.slot, got_rsp.slot);
                        err_cnt++;
                    end
                    case (want_rsp.status)
                        lpht_pkg::STAT_OK:   n_ok++;
                        lpht_pkg::STAT_FULL: n_full++;
                        default:             n_missing++;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted_results.push_back(apply_table_op(s_tdata[CMD_W-1:0],
                                                           s_tdata[CMD_W +: KEY_W]));
            end
            // one long hold-off so the block fills up and blocks its input
            if (!held && rsp_cnt == STALL_AT)
            begin
                held     = 1'b1;
                hold_cnt = STALL_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles with no request and no result taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int ins_pct;
        int r;
        table_req_t req;

        ins_pct = 50;
        for (int i = 0; i < TS; i++)
        begin
            table_used[i] = 1'b0;
            table_key[i]  = '0;
        end
        for (int i = 0; i < POOL_N; i++)
        begin
            pool_key[i] = random_key();
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, unused command, collision chain, empty home
        push_req(lpht_pkg::CMD_SEARCH, 64'h1);
        push_req(CMD_UNUSED, 64'h5);
        push_req(lpht_pkg::CMD_INSERT, 64'h1);
        push_req(lpht_pkg::CMD_INSERT, 64'h100);
        push_req(lpht_pkg::CMD_DELETE, 64'h1);
        push_req(lpht_pkg::CMD_SEARCH, 64'h100);
        push_req(lpht_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(lpht_pkg::CMD_INSERT, 64'h0);
        push_req(lpht_pkg::CMD_DELETE, 64'h100);
        push_req(lpht_pkg::CMD_DELETE, 64'h100);
        // fill the table, overflow it, then miss with every slot taken
        for (int i = 0; i < TS - 2; i++)
        begin
            push_req(lpht_pkg::CMD_INSERT, pool_key[i]);
        end
        push_req(lpht_pkg::CMD_INSERT, pool_key[POOL_N-2]);
        push_req(lpht_pkg::CMD_SEARCH, pool_key[POOL_N-1]);

        // Random: mostly pool keys so that hits, duplicates and chains occur
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 15;
                    1:       ins_pct = 50;
                    default: ins_pct = 85;
                endcase
            end
            if (n == 500)
            begin
                wait_drained();
            end
            if (n == 900)
            begin
                quiet = 1'b1;
            end
            if (n == 1200)
            begin
                quiet = 1'b0;
            end
            while (request_q.size() >= 4)
            begin
                @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                req.cmd = CMD_UNUSED;
            end
            else if ($urandom_range(0, 99) < ins_pct)
            begin
                req.cmd = lpht_pkg::CMD_INSERT;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                req.cmd = lpht_pkg::CMD_SEARCH;
            end
            else
            begin
                req.cmd = lpht_pkg::CMD_DELETE;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                req.key = pool_key[$urandom_range(0, POOL_N - 1)];
            end
            else
            begin
                req.key = random_key();
            end
            request_q.push_back(req);
        end

        wait_drained();
        repeat (TAIL_WAIT) @(negedge clk);

        $display("Ran %0d requests: %0d hits or inserts, %0d full, %0d misses,",
                 rsp_cnt, n_ok, n_full, n_missing);
        $display("over collision chains, wraparound, empty homes and a full table.");
        if (err_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lpht_pkg.sv
sv/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
